@@ design/lrd_pkg.sv @@
// Shared types and constants of the log record deframer.
// Holds the result, record, error and phase codes and the result transaction struct.
// No dependencies.
package lrd_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_INSERT_CODE     = 2'd0,
    CFG_UPDATE_CODE     = 2'd1,
    CFG_DELETE_CODE     = 2'd2,
    CFG_CHECKPOINT_CODE = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    RES_WORD      = 2'd0,
    RES_RECORD    = 2'd1,
    RES_CLEAN_END = 2'd2,
    RES_ERROR     = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    KIND_INSERT     = 2'd0,
    KIND_UPDATE     = 2'd1,
    KIND_DELETE     = 2'd2,
    KIND_CHECKPOINT = 2'd3
  } record_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_CHECKSUM  = 2'd1,
    ERR_OPCODE    = 2'd2,
    ERR_TRUNCATED = 2'd3
  } error_code_t;

  typedef enum logic [9:0] {
    PH_LEN     = 10'b00_0000_0001,
    PH_SEQ     = 10'b00_0000_0010,
    PH_OP      = 10'b00_0000_0100,
    PH_ID      = 10'b00_0000_1000,
    PH_DIM     = 10'b00_0001_0000,
    PH_WORD    = 10'b00_0010_0000,
    PH_DELID   = 10'b00_0100_0000,
    PH_CKPT    = 10'b00_1000_0000,
    PH_TRAIL   = 10'b01_0000_0000,
    PH_DISCARD = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [63:0]  sequence_number;
    record_kind_t record_kind;
    logic [63:0]  entry_id;
    logic [31:0]  dimension_count;
    logic [63:0]  checkpoint_sequence;
    logic [31:0]  vector_word;
    logic         is_last_word;
    error_code_t  error_code;
  } result_t;

endpackage

@@ design/lrd_if.sv @@
// Channel interfaces of the log record deframer: the byte stream and the results.
// Plain valid/ready handshake; no dependencies.
interface lrd_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lrd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [63:0] sequence_number;
  logic [1:0]  record_kind;
  logic [63:0] entry_id;
  logic [31:0] dimension_count;
  logic [63:0] checkpoint_sequence;
  logic [31:0] vector_word;
  logic        is_last_word;
  logic [1:0]  error_code;

  modport source (
    output valid, output result_kind, output sequence_number, output record_kind,
    output entry_id, output dimension_count, output checkpoint_sequence,
    output vector_word, output is_last_word, output error_code, input ready
  );
  modport sink (
    input valid, input result_kind, input sequence_number, input record_kind,
    input entry_id, input dimension_count, input checkpoint_sequence,
    input vector_word, input is_last_word, input error_code, output ready
  );
endinterface

@@ design/lrd_parser.sv @@
// Record parser of the log record deframer: opcode registers, parse state and
// the per-byte next-state and result logic. Depends on lrd_pkg.
module lrd_parser
  import lrd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     take,
  input  logic [7:0]               data_byte,
  input  logic                     end_of_stream,
  output logic                     res_valid,
  output result_t                  res
);

  logic [31:0] insert_code, update_code, delete_code, checkpoint_code;

  phase_t       phase, phase_next;
  logic [2:0]   byte_count, byte_count_next;
  logic [31:0]  running_sum, running_sum_next;
  logic [63:0]  field_shift, field_shift_next;
  logic [63:0]  held_sequence, held_sequence_next;
  record_kind_t held_kind, held_kind_next;
  logic [63:0]  held_id, held_id_next;
  logic [31:0]  held_dimensions, held_dimensions_next;
  logic [31:0]  words_left, words_left_next;
  logic [63:0]  held_checkpoint, held_checkpoint_next;

  logic [63:0] field_value;
  logic [31:0] sum_added;
  logic        wide_field;
  logic        field_done;
  logic [31:0] word_value;

  assign field_value = field_shift | (64'(data_byte) << {byte_count, 3'b000});
  assign word_value  = field_value[31:0];
  assign sum_added   = (phase == PH_LEN || phase == PH_TRAIL) ? running_sum
                     : running_sum + 32'(data_byte);
  assign wide_field  = (phase == PH_SEQ) || (phase == PH_ID) || (phase == PH_DELID)
                     || (phase == PH_CKPT);
  assign field_done  = wide_field ? (byte_count == 3'd7) : (byte_count == 3'd3);

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    running_sum_next     = running_sum;
    field_shift_next     = field_shift;
    held_sequence_next   = held_sequence;
    held_kind_next       = held_kind;
    held_id_next         = held_id;
    held_dimensions_next = held_dimensions;
    words_left_next      = words_left;
    held_checkpoint_next = held_checkpoint;
    res_valid            = 1'b0;
    res                  = '0;

    if (end_of_stream) begin
      phase_next       = PH_LEN;
      byte_count_next  = 3'd0;
      field_shift_next = '0;
      running_sum_next = '0;
      if (phase == PH_DISCARD) begin
        res_valid = 1'b0;
      end else if (phase == PH_LEN && byte_count == 3'd0) begin
        res_valid       = 1'b1;
        res.result_kind = RES_CLEAN_END;
      end else begin
        res_valid       = 1'b1;
        res.result_kind = RES_ERROR;
        res.error_code  = ERR_TRUNCATED;
      end
    end else if (phase != PH_DISCARD) begin
      running_sum_next = sum_added;
      if (!field_done) begin
        byte_count_next  = byte_count + 3'd1;
        field_shift_next = field_value;
      end else begin
        byte_count_next  = 3'd0;
        field_shift_next = '0;
        unique case (phase)
          PH_LEN: begin
            running_sum_next = '0;
            phase_next       = PH_SEQ;
          end
          PH_SEQ: begin
            held_sequence_next = field_value;
            phase_next         = PH_OP;
          end
          PH_OP: begin
            held_id_next         = '0;
            held_dimensions_next = '0;
            held_checkpoint_next = '0;
            words_left_next      = '0;
            priority if (word_value == insert_code) begin
              held_kind_next = KIND_INSERT;
              phase_next     = PH_ID;
            end else if (word_value == update_code) begin
              held_kind_next = KIND_UPDATE;
              phase_next     = PH_ID;
            end else if (word_value == delete_code) begin
              held_kind_next = KIND_DELETE;
              phase_next     = PH_DELID;
            end else if (word_value == checkpoint_code) begin
              held_kind_next = KIND_CHECKPOINT;
              phase_next     = PH_CKPT;
            end else begin
              phase_next      = PH_DISCARD;
              res_valid       = 1'b1;
              res.result_kind = RES_ERROR;
              res.error_code  = ERR_OPCODE;
            end
          end
          PH_ID: begin
            held_id_next = field_value;
            phase_next   = PH_DIM;
          end
          PH_DIM: begin
            held_dimensions_next = word_value;
            words_left_next      = word_value;
            phase_next           = (word_value != 32'd0) ? PH_WORD : PH_TRAIL;
          end
          PH_WORD: begin
            words_left_next         = words_left - 32'd1;
            res_valid               = 1'b1;
            res.result_kind         = RES_WORD;
            res.sequence_number     = held_sequence;
            res.record_kind         = held_kind;
            res.entry_id            = held_id;
            res.dimension_count     = held_dimensions;
            res.checkpoint_sequence = held_checkpoint;
            res.vector_word         = word_value;
            res.is_last_word        = (words_left == 32'd1);
            if (words_left == 32'd1) begin
              phase_next = PH_TRAIL;
            end
          end
          PH_DELID: begin
            held_id_next = field_value;
            phase_next   = PH_TRAIL;
          end
          PH_CKPT: begin
            held_checkpoint_next = field_value;
            phase_next           = PH_TRAIL;
          end
          PH_TRAIL: begin
            running_sum_next = '0;
            res_valid        = 1'b1;
            if (word_value == running_sum) begin
              phase_next              = PH_LEN;
              res.result_kind         = RES_RECORD;
              res.sequence_number     = held_sequence;
              res.record_kind         = held_kind;
              res.entry_id            = held_id;
              res.dimension_count     = held_dimensions;
              res.checkpoint_sequence = held_checkpoint;
            end else begin
              phase_next      = PH_DISCARD;
              res.result_kind = RES_ERROR;
              res.error_code  = ERR_CHECKSUM;
            end
          end
          default: begin
            phase_next = PH_DISCARD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_code     <= 32'd0;
      update_code     <= 32'd1;
      delete_code     <= 32'd2;
      checkpoint_code <= 32'd3;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_INSERT_CODE:     insert_code     <= cfg_data;
        CFG_UPDATE_CODE:     update_code     <= cfg_data;
        CFG_DELETE_CODE:     delete_code     <= cfg_data;
        CFG_CHECKPOINT_CODE: checkpoint_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN;
      byte_count      <= '0;
      running_sum     <= '0;
      field_shift     <= '0;
      held_sequence   <= '0;
      held_kind       <= KIND_INSERT;
      held_id         <= '0;
      held_dimensions <= '0;
      words_left      <= '0;
      held_checkpoint <= '0;
    end else if (take) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      running_sum     <= running_sum_next;
      field_shift     <= field_shift_next;
      held_sequence   <= held_sequence_next;
      held_kind       <= held_kind_next;
      held_id         <= held_id_next;
      held_dimensions <= held_dimensions_next;
      words_left      <= words_left_next;
      held_checkpoint <= held_checkpoint_next;
    end
  end

endmodule

@@ design/lrd_out_buffer.sv @@
// Two-entry result buffer of the log record deframer: an output register and a
// skid register, so the input ready is registered and never follows the output ready
// directly. Depends on lrd_pkg.
module lrd_out_buffer
  import lrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    advance;

  // The main register moves when it is empty or its transaction completes.
  assign advance = !out_valid || out_ready;
  assign space   = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ design/log_record_deframer_top.sv @@
// Top level of the log record deframer: byte stream in, record results out.
// Depends on lrd_pkg, lrd_if.sv, lrd_parser and lrd_out_buffer.
//
//   Channel  Direction  Transaction carries
//   stream   sink       data_byte, end_of_stream (one stream byte or the end mark)
//   result   source     result_kind and the record fields, at most one per byte
//   cfg      write      cfg_we, cfg_index, cfg_data (opcode registers 0 to 3)
//
// One byte is taken every clock cycle while the skid register is free; the parse
// state is registered as it is taken; a result goes to the output or skid register.
// A two-entry output buffer (output register plus skid register) decouples the
// sides: stream.ready is low only while both entries are full.
// Reset is synchronous and active high; it restores the opcode registers to
// 0, 1, 2 and 3 and starts the parser waiting for a length field.
module log_record_deframer_top
  import lrd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  lrd_stream_if.sink               stream,
  lrd_result_if.source             result
);

  logic    take;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // A byte transaction completes whenever the skid register is free.
  assign stream.ready = space;
  assign take         = stream.valid && space;

  lrd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .data_byte    (stream.data_byte),
    .end_of_stream(stream.end_of_stream),
    .res_valid    (res_valid),
    .res          (res)
  );

  lrd_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.result_kind         = out_data.result_kind;
  assign result.sequence_number     = out_data.sequence_number;
  assign result.record_kind         = out_data.record_kind;
  assign result.entry_id            = out_data.entry_id;
  assign result.dimension_count     = out_data.dimension_count;
  assign result.checkpoint_sequence = out_data.checkpoint_sequence;
  assign result.vector_word         = out_data.vector_word;
  assign result.is_last_word        = out_data.is_last_word;
  assign result.error_code          = out_data.error_code;

endmodule
